// ===== rtl/acor_pkg.sv =====
// ----------------------------------------------------------------------------
// acor_pkg
// shared types and constants of the advert cache with oldest-entry replacement
// ----------------------------------------------------------------------------
`default_nettype none

package acor_pkg;

	localparam int KIND_W = 2;
	localparam int ADDR_W = 48;
	localparam int BYTE_W = 8;
	localparam int TIME_W = 63;
	localparam int SLOT_W = 4;

	// command codes
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// one stored cache entry
	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [ADDR_W-1:0]        addr;
		logic [BYTE_W-1:0]        mfg_len;
		logic signed [BYTE_W-1:0] sig;
		logic [TIME_W-1:0]        last_seen;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/advert_cache_oldest_replace_top.sv =====
// ----------------------------------------------------------------------------
// advert_cache_oldest_replace_top
// fully associative advertiser cache, refresh on match, else fill or replace oldest
// ----------------------------------------------------------------------------
// A small fully associative cache keyed by address kind and 48-bit device
// address. An update item refreshes the first valid entry whose key matches;
// otherwise it fills the lowest free slot or, with all slots in use, replaces
// the entry with the smallest last-seen time (lowest index on a tie). A lookup
// item returns the first valid matching entry, or found = 0 with all other
// result fields zero. Exactly one result item follows each input item. The
// entries sit in a memory with one write and one registered read port that is
// scanned one entry per cycle by a small sequencer feeding one shared key
// compare and one 63-bit time compare. A hit ends the scan early. The block
// goes back to idle before it takes the next item. A new item is accepted
// only when the sequencer is idle; a finished result waits in the output
// register without holding up the next item, and the block only stalls at
// the end of a scan if the previous result has not been taken yet. Valid
// bits are cleared at reset, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module advert_cache_oldest_replace_top
	import acor_pkg::*;
#(
	parameter int CACHE_ENTRIES = 12
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// input channel
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     cmd,
	input  wire logic [KIND_W-1:0]        address_kind,
	input  wire logic [ADDR_W-1:0]        device_address,
	input  wire logic [BYTE_W-1:0]        mfg_length,
	input  wire logic signed [BYTE_W-1:0] signal_strength,
	input  wire logic [TIME_W-1:0]        now_time,
	// result channel
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          found,
	output logic [SLOT_W-1:0]             slot,
	output logic [BYTE_W-1:0]             stored_mfg_length,
	output logic signed [BYTE_W-1:0]      stored_signal
);

	// index and scan counter widths; the counter also holds the entry count
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

	state_t state_q;

	// latched input item
	logic                     cmd_q;
	logic [KIND_W-1:0]        kind_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [BYTE_W-1:0]        mlen_q;
	logic signed [BYTE_W-1:0] sig_q;
	logic [TIME_W-1:0]        time_q;

	// entry storage: valid bits in flops, the rest in a memory
	logic [CACHE_ENTRIES-1:0] valid_q;
	entry_t                   mem [CACHE_ENTRIES];

	// read issue stage
	logic [CNT_W-1:0] cnt_q;
	logic             issue;
	logic [IDX_W-1:0] rd_idx;

	// compare stage, one entry per cycle
	entry_t           rd_data_s1;
	logic             live_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;

	// scan bookkeeping
	logic                     hit_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic [BYTE_W-1:0]        hit_mlen_q;
	logic signed [BYTE_W-1:0] hit_sig_q;
	logic                     have_free_q;
	logic [IDX_W-1:0]         free_idx_q;
	logic                     have_old_q;
	logic [IDX_W-1:0]         old_idx_q;
	logic [TIME_W-1:0]        old_time_q;

	// shared compare unit
	logic key_hit;
	logic older;

	// finish step
	logic             out_free;
	logic             finish_go;
	logic             mem_we;
	logic [IDX_W-1:0] target_idx;
	entry_t           wr_data;

	// output register
	logic                     out_valid_q;
	logic                     found_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [BYTE_W-1:0]        out_mlen_q;
	logic signed [BYTE_W-1:0] out_sig_q;

	assign in_ready = (state_q == ST_IDLE);

	// issue one read per cycle while entries remain
	assign issue  = (state_q == ST_SCAN) && (cnt_q != CNT_END);
	assign rd_idx = cnt_q[IDX_W-1:0];

	// key and age compare on the entry just read
	assign key_hit = vld_s1 && (rd_data_s1.kind == kind_q) && (rd_data_s1.addr == addr_q);
	assign older   = !have_old_q || (rd_data_s1.last_seen < old_time_q);

	// output slot is free now or being emptied this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign finish_go = (state_q == ST_FINISH) && out_free;

	// refresh the hit, else fill the lowest free slot, else replace the oldest
	always_comb begin
		if (hit_q) begin
			target_idx = hit_idx_q;
		end else if (have_free_q) begin
			target_idx = free_idx_q;
		end else begin
			target_idx = old_idx_q;
		end
	end

	assign mem_we  = finish_go && (cmd_q == CMD_UPDATE);
	assign wr_data = '{kind: kind_q, addr: addr_q, mfg_len: mlen_q, sig: sig_q,
		last_seen: time_q};

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[target_idx] <= wr_data;
		end
		rd_data_s1 <= mem[rd_idx];
	end

	// latched item and scan payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			kind_q <= address_kind;
			addr_q <= device_address;
			mlen_q <= mfg_length;
			sig_q  <= signal_strength;
			time_q <= now_time;
		end
		if (issue) begin
			idx_s1 <= rd_idx;
			vld_s1 <= valid_q[rd_idx];
		end
	end

	// sequencer and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			live_s1     <= 1'b0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_mlen_q  <= '0;
			hit_sig_q   <= '0;
			have_free_q <= 1'b0;
			free_idx_q  <= '0;
			have_old_q  <= 1'b0;
			old_idx_q   <= '0;
			old_time_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q     <= ST_SCAN;
						cnt_q       <= '0;
						live_s1     <= 1'b0;
						hit_q       <= 1'b0;
						have_free_q <= 1'b0;
						have_old_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					// issue stage
					live_s1 <= issue;
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					// compare stage
					if (live_s1) begin
						if (key_hit) begin
							// first match ends the scan
							hit_q      <= 1'b1;
							hit_idx_q  <= idx_s1;
							hit_mlen_q <= rd_data_s1.mfg_len;
							hit_sig_q  <= rd_data_s1.sig;
							live_s1    <= 1'b0;
							state_q    <= ST_FINISH;
						end else begin
							if (vld_s1) begin
								if (older) begin
									have_old_q <= 1'b1;
									old_idx_q  <= idx_s1;
									old_time_q <= rd_data_s1.last_seen;
								end
							end else if (!have_free_q) begin
								have_free_q <= 1'b1;
								free_idx_q  <= idx_s1;
							end
							if (idx_s1 == IDX_LAST) begin
								live_s1 <= 1'b0;
								state_q <= ST_FINISH;
							end
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						if (cmd_q == CMD_UPDATE) begin
							valid_q[target_idx] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (finish_go) begin
			found_q <= hit_q;
			if (cmd_q == CMD_UPDATE) begin
				slot_q     <= SLOT_W'(target_idx);
				out_mlen_q <= '0;
				out_sig_q  <= '0;
			end else if (hit_q) begin
				slot_q     <= SLOT_W'(hit_idx_q);
				out_mlen_q <= hit_mlen_q;
				out_sig_q  <= hit_sig_q;
			end else begin
				slot_q     <= '0;
				out_mlen_q <= '0;
				out_sig_q  <= '0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign found             = found_q;
	assign slot              = slot_q;
	assign stored_mfg_length = out_mlen_q;
	assign stored_signal     = out_sig_q;

endmodule

`default_nettype wire
